[src/bpa_pkg.sv]
// Shared types and constants for the bitmap page allocator.
// No dependencies; every other file but bpa_ram imports this package.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 4096;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  // One map word covers this many pages.
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORD_IW   = $clog2(WORD_BITS);

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PCNT_W = 13;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STS_W  = 3;
  localparam int unsigned CIDX_W = 2;
  localparam int unsigned CDAT_W = 32;

  localparam logic [ADDR_W-1:0] RAM_BASE_RST   = '0;
  localparam logic [PCNT_W-1:0] PAGE_COUNT_RST = PCNT_W'(4096);
  localparam logic [PCNT_W-1:0] RESERVED_RST   = PCNT_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 3'd0,
    STS_NO_FREE  = 3'd1,
    STS_MISALIGN = 3'd2,
    STS_RANGE    = 3'd3,
    STS_NOT_USED = 3'd4
  } sts_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_RAM_BASE   = 2'd0,
    CFG_PAGE_COUNT = 2'd1,
    CFG_RESERVED   = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_REPLY
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic clr_valid;
    logic row_next;
    logic ram_rd;
    logic wr_init;
    logic wr_alloc;
    logic wr_free;
    logic set_sts;
    sts_e sts;
    logic res_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic init_more;
    logic row_in_range;
    logic found;
    logic align_ok;
    logic range_ok;
    logic bit_used;
  } stat_t;

endpackage

[src/bpa_if.sv]
// Request and response channel interfaces of the bitmap page allocator.
// Depends on bpa_pkg for field widths.
`timescale 1ns / 1ps

interface bpa_req_if import bpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] page_addr;

  modport source (output valid, output req_type, output page_addr, input ready);
  modport sink   (input valid, input req_type, input page_addr, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [ADDR_W-1:0] granted_addr;

  modport source (output valid, output status, output granted_addr, input ready);
  modport sink   (input valid, input status, input granted_addr, output ready);
endinterface

[src/bitmap_page_allocator.sv]
// Top level of the bitmap page allocator: controller, datapath and channels.
// Depends on bpa_pkg, bpa_if, bpa_ctrl, bpa_dp (which holds bpa_ram).
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------
//   req_i    | in  | valid / ready      | req_type[1:0], page_addr[31:0]
//   rsp_o    | out | valid / ready      | status[2:0], granted_addr[31:0]
//   cfg      | in  | cfg_we_i, no ready | cfg_idx_i[1:0], cfg_data_i[31:0]
//
// One request is in work at a time; the map is 64-page words in a RAM with
// registered read, so each scanned row takes a read state and a check state.
// Init writes each row that holds reserved pages; allocate reads rows up to
// the first row with a free page, or every row in range when none is free;
// free reads its single row, and skips the read on a bad address.
// Reset clears a valid bit per row at once, so the map reads all free with
// no clearing pass; init likewise drops all valid bits when it is taken.
// The result sits in an output register; a stalled rsp_o holds the beat and
// the next request is taken meanwhile, finishing once the register drains.
`timescale 1ns / 1ps

module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CDAT_W-1:0] cfg_data_i,
  bpa_req_if.sink           req_i,
  bpa_rsp_if.source         rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence the request: scan, check, write back, reply.
  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold config, the map and the result beat.
  bpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_i.req_type),
    .page_addr_i    (req_i.page_addr),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (rsp_o.status),
    .granted_addr_o (rsp_o.granted_addr)
  );

endmodule

[src/bpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bpa_ctrl.sv]
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives bpa_dp through cmd_t and reads stat_t.
`timescale 1ns / 1ps

module bpa_ctrl import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  stat_t            stat_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (req_e'(req_type_i))
            REQ_INIT:  state_d = S_INIT;
            REQ_ALLOC: state_d = S_ALLOC_RD;
            REQ_FREE:  state_d = S_FREE_RD;
            REQ_NONE:  state_d = S_REPLY;
            default:   state_d = S_REPLY;
          endcase
        end
      end
      S_INIT: begin
        if (!stat_i.init_more) state_d = S_REPLY;
      end
      S_ALLOC_RD: begin
        state_d = stat_i.row_in_range ? S_ALLOC_CHK : S_REPLY;
      end
      S_ALLOC_CHK: begin
        state_d = stat_i.found ? S_REPLY : S_ALLOC_RD;
      end
      S_FREE_RD: begin
        if (stat_i.align_ok && stat_i.range_ok) state_d = S_FREE_CHK;
        else state_d = S_REPLY;
      end
      S_FREE_CHK: state_d = S_REPLY;
      S_REPLY: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sts  = STS_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture   = 1'b1;
          cmd_o.clr_valid = (req_e'(req_type_i) == REQ_INIT);
        end
      end
      S_INIT: begin
        if (stat_i.init_more) begin
          cmd_o.wr_init  = 1'b1;
          cmd_o.row_next = 1'b1;
        end
      end
      S_ALLOC_RD: begin
        if (stat_i.row_in_range) begin
          cmd_o.ram_rd = 1'b1;
        end else begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = STS_NO_FREE;
        end
      end
      S_ALLOC_CHK: begin
        if (stat_i.found) cmd_o.wr_alloc = 1'b1;
        else cmd_o.row_next = 1'b1;
      end
      S_FREE_RD: begin
        if (!stat_i.align_ok) begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = STS_MISALIGN;
        end else if (!stat_i.range_ok) begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = STS_RANGE;
        end else begin
          cmd_o.ram_rd = 1'b1;
        end
      end
      S_FREE_CHK: begin
        if (stat_i.bit_used) begin
          cmd_o.wr_free = 1'b1;
        end else begin
          cmd_o.set_sts = 1'b1;
          cmd_o.sts     = STS_NOT_USED;
        end
      end
      S_REPLY: begin
        cmd_o.res_load = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/bpa_dp.sv]
// Datapath of the bitmap page allocator: config registers, map RAM with
// row valid bits, row counter, free-bit search and result registers.
// Depends on bpa_pkg and bpa_ram.
`timescale 1ns / 1ps

module bpa_dp import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CDAT_W-1:0] cfg_data_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [ADDR_W-1:0] page_addr_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic [STS_W-1:0]  status_o,
  output logic [ADDR_W-1:0] granted_addr_o
);

  localparam int unsigned ROWS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned RC_W  = $clog2(ROWS + 1);
  localparam int unsigned SHIFT = $clog2(PAGE_BYTES);

  // Configuration registers.
  logic [ADDR_W-1:0] ram_base_q, ram_base_d;
  logic [PCNT_W-1:0] page_count_q, page_count_d;
  logic [PCNT_W-1:0] reserved_q, reserved_d;

  always_comb begin
    ram_base_d   = ram_base_q;
    page_count_d = page_count_q;
    reserved_d   = reserved_q;
    if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_RAM_BASE:   ram_base_d   = cfg_data_i;
        CFG_PAGE_COUNT: page_count_d = cfg_data_i[PCNT_W-1:0];
        CFG_RESERVED:   reserved_d   = cfg_data_i[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective page count and effective reserved count.
  logic [PCNT_W-1:0] n_eff, r_eff;
  assign n_eff = (32'(page_count_q) > 32'(MAX_PAGES)) ? PCNT_W'(MAX_PAGES) : page_count_q;
  assign r_eff = (reserved_q < n_eff) ? reserved_q : n_eff;

  // Free-request decode from the incoming beat.
  logic [ADDR_W-1:0] off, qidx;
  assign off  = page_addr_i - ram_base_q;
  assign qidx = off >> SHIFT;

  logic [RC_W-1:0]    row_q, row_d;
  logic [WORD_IW-1:0] fbit_q, fbit_d;
  logic               align_ok_q, align_ok_d, range_ok_q, range_ok_d;
  logic [ROWS-1:0]    valid_q, valid_d;
  sts_e               sts_q, sts_d;
  logic [ADDR_W-1:0]  grant_q, grant_d;
  sts_e               res_sts_q;
  logic [ADDR_W-1:0]  res_addr_q;

  logic [ROW_W-1:0]          row_idx;
  logic [RC_W+WORD_IW-1:0]   base;
  logic [31:0]               n_left, r_left;
  logic [WORD_BITS-1:0]      rdata, word, avail, init_word, wdata, onehot_f, onehot_a;
  logic [WORD_IW-1:0]        fidx;
  logic                      we;

  assign row_idx = row_q[ROW_W-1:0];
  assign base    = {row_q, {WORD_IW{1'b0}}};
  assign n_left  = 32'(n_eff) - 32'(base);
  assign r_left  = 32'(r_eff) - 32'(base);

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (row_idx),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (row_idx),
    .rdata_o (rdata)
  );

  // A row never written since reset or init reads as all free.
  assign word = valid_q[row_idx] ? rdata : '0;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j]     = !word[j] && (32'(j) < n_left);
      init_word[j] = (32'(j) < r_left);
    end
  end

  // Lowest free page in the row.
  always_comb begin
    fidx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) fidx = WORD_IW'(j);
    end
  end

  assign onehot_a = WORD_BITS'(1) << fidx;
  assign onehot_f = WORD_BITS'(1) << fbit_q;

  always_comb begin
    wdata = init_word;
    if (cmd_i.wr_alloc) wdata = word | onehot_a;
    else if (cmd_i.wr_free) wdata = word & ~onehot_f;
  end

  assign we = cmd_i.wr_init || cmd_i.wr_alloc || cmd_i.wr_free;

  assign stat_o.init_more    = (32'(base) < 32'(r_eff));
  assign stat_o.row_in_range = (32'(base) < 32'(n_eff));
  assign stat_o.found        = |avail;
  assign stat_o.align_ok     = align_ok_q;
  assign stat_o.range_ok     = range_ok_q;
  assign stat_o.bit_used     = word[fbit_q];

  always_comb begin
    row_d      = row_q;
    fbit_d     = fbit_q;
    align_ok_d = align_ok_q;
    range_ok_d = range_ok_q;
    valid_d    = valid_q;
    sts_d      = sts_q;
    grant_d    = grant_q;
    if (cmd_i.capture) begin
      row_d      = (req_e'(req_type_i) == REQ_FREE) ? qidx[RC_W+WORD_IW-1:WORD_IW] : '0;
      fbit_d     = qidx[WORD_IW-1:0];
      align_ok_d = (off[SHIFT-1:0] == '0);
      range_ok_d = (qidx < 32'(n_eff));
      sts_d      = STS_OK;
      grant_d    = '0;
    end
    if (cmd_i.row_next) row_d = row_q + RC_W'(1);
    if (cmd_i.clr_valid) valid_d = '0;
    if (we) valid_d[row_idx] = 1'b1;
    if (cmd_i.set_sts) sts_d = cmd_i.sts;
    if (cmd_i.wr_alloc) begin
      grant_d = ram_base_q + (32'({row_idx, fidx}) << SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q   <= RAM_BASE_RST;
      page_count_q <= PAGE_COUNT_RST;
      reserved_q   <= RESERVED_RST;
      valid_q      <= '0;
    end else begin
      ram_base_q   <= ram_base_d;
      page_count_q <= page_count_d;
      reserved_q   <= reserved_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    fbit_q     <= fbit_d;
    align_ok_q <= align_ok_d;
    range_ok_q <= range_ok_d;
    sts_q      <= sts_d;
    grant_q    <= grant_d;
    if (cmd_i.res_load) begin
      res_sts_q  <= sts_q;
      res_addr_q <= grant_q;
    end
  end

  assign status_o       = res_sts_q;
  assign granted_addr_o = res_addr_q;

endmodule

[src/bpa_checker.sv]
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg for status codes and widths.
`timescale 1ns / 1ps

module bpa_checker import bpa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STS_W-1:0]  status,
  input logic [ADDR_W-1:0] granted_addr
);

  // A beat waiting on rsp_o stays up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  // A waiting beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(status) && $stable(granted_addr))
    else $error("response payload changed while stalled");

  // One request at a time: no beat is taken right after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while one is in work");

  // A failed request never grants an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (status != STS_OK) |-> granted_addr == '0)
    else $error("address granted on a failed request");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> status <= STS_NOT_USED)
    else $error("undefined status code");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .status       (rsp_o.status),
  .granted_addr (rsp_o.granted_addr)
);
